/* src/ps2c_pkg.sv */
// Package for the PS/2 mouse packet cursor core.
// Holds the packet type, header bit positions, register indexes and reset values.
// No dependencies.
package ps2c_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned OUT_W   = 12;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam int unsigned HDR_SYNC  = 3;
  localparam int unsigned HDR_XSIGN = 4;
  localparam int unsigned HDR_YSIGN = 5;
  localparam int unsigned HDR_XOVF  = 6;
  localparam int unsigned HDR_YOVF  = 7;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam int unsigned CURSOR_X_RST = 320;
  localparam int unsigned CURSOR_Y_RST = 240;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] xbyte;
    logic [BYTE_W-1:0] ybyte;
  } packet_t;

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_X   = 3'b010,
    PH_Y   = 3'b100
  } phase_t;

endpackage

/* src/ps2c_front.sv */
// Front end: takes port bytes, drops non-aux bytes and unsynced headers,
// and assembles three-byte packets for the queue. Depends on ps2c_pkg.
module ps2c_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       port_byte,
  input  logic             from_aux,
  output logic             push,
  output ps2c_pkg::packet_t push_data
);
  import ps2c_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [BYTE_W-1:0] header;
  logic [BYTE_W-1:0] xbyte;

  always_comb begin
    phase_next = phase;
    push       = 1'b0;
    if (accept && from_aux) begin
      unique case (phase)
        PH_X: phase_next = PH_Y;
        PH_Y: begin
          phase_next = PH_HDR;
          push       = 1'b1;
        end
        default: phase_next = port_byte[HDR_SYNC] ? PH_X : PH_HDR;
      endcase
    end
  end

  assign push_data = '{header: header, xbyte: xbyte, ybyte: port_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR;
      header <= '0;
      xbyte  <= '0;
    end else begin
      phase <= phase_next;
      if (accept && from_aux && phase == PH_X) begin
        xbyte <= port_byte;
      end
      if (accept && from_aux && phase != PH_X && phase != PH_Y && port_byte[HDR_SYNC]) begin
        header <= port_byte;
      end
    end
  end

endmodule

/* src/ps2c_fifo.sv */
// Short packet queue between front and back ends.
// Depends on ps2c_pkg.
module ps2c_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ps2c_pkg::packet_t push_data,
  input  logic             pop,
  output ps2c_pkg::packet_t head,
  output logic             full,
  output logic             empty
);
  import ps2c_pkg::*;

  packet_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/ps2c_back.sv */
// Back end: screen size registers, cursor update with clamp, result register.
// Depends on ps2c_pkg.
module ps2c_back #(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [12:0]      wr_data,
  input  logic             q_valid,
  input  ps2c_pkg::packet_t q_head,
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [11:0]      cursor_x,
  output logic [11:0]      cursor_y,
  output logic [2:0]       buttons
);
  import ps2c_pkg::*;

  localparam int LIM_W = COORD_BITS + 1;
  localparam int SUM_W = COORD_BITS + 2;
  localparam int CMP_W = (LIM_W > DIM_W) ? LIM_W : DIM_W;
  localparam logic [CMP_W-1:0] SPAN = CMP_W'(1) << COORD_BITS;
  localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(CURSOR_X_RST);
  localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(CURSOR_Y_RST);

  logic [DIM_W-1:0]      screen_width;
  logic [DIM_W-1:0]      screen_height;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic signed [8:0]     dx;
  logic signed [8:0]     dy;
  logic signed [SUM_W-1:0] nx;
  logic signed [SUM_W-1:0] ny;

  function automatic logic [LIM_W-1:0] eff_limit(input logic [DIM_W-1:0] dim);
    logic [CMP_W-1:0] w;
    logic [CMP_W-1:0] r;
    begin
      w = CMP_W'(dim);
      if (w == '0) r = CMP_W'(1);
      else if (w > SPAN) r = SPAN;
      else r = w;
      return LIM_W'(r);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                  input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] top;
    begin
      top = lim - 1'b1;
      if (v < 0) return '0;
      else if (v[LIM_W-1:0] >= lim) return top[COORD_BITS-1:0];
      else return v[COORD_BITS-1:0];
    end
  endfunction

  assign take = q_valid && (!out_valid || !out_stall);

  always_comb begin
    dx = q_head.header[HDR_XOVF] ? 9'sd0 : $signed({q_head.header[HDR_XSIGN], q_head.xbyte});
    dy = q_head.header[HDR_YOVF] ? 9'sd0 : $signed({q_head.header[HDR_YSIGN], q_head.ybyte});
    nx = $signed({2'b00, pos_x}) + SUM_W'(dx);
    ny = $signed({2'b00, pos_y}) - SUM_W'(dy);
    pos_x_next = clamp(nx, eff_limit(screen_width));
    pos_y_next = clamp(ny, eff_limit(screen_height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SCREEN_WIDTH:  screen_width  <= wr_data;
        REG_SCREEN_HEIGHT: screen_height <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= POS_X_RST;
      pos_y     <= POS_Y_RST;
      out_valid <= 1'b0;
    end else if (take) begin
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cursor_x <= OUT_W'(pos_x_next);
      cursor_y <= OUT_W'(pos_y_next);
      buttons  <= q_head.header[BTN_W-1:0];
    end
  end

endmodule

/* src/ps2_mouse_packet_cursor_core.sv */
// PS/2 mouse packet decoder with clamped absolute cursor. Top level.
// A third byte pushes the packet to the queue, then to the result register.
// Throughput: one byte per cycle unless in_stall (queue full); the two-entry
// packet queue and result register let the byte side run while a result waits.
// Reset (rst, synchronous): phase to header, cursor to 320,240, screen 640x480.
// Depends on ps2c_pkg, ps2c_front, ps2c_fifo, ps2c_back.
module ps2_mouse_packet_cursor_core #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  port_byte,
  input  logic        from_aux,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] cursor_x,
  output logic [11:0] cursor_y,
  output logic [2:0]  buttons,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [12:0] wr_data
);
  import ps2c_pkg::*;

  logic    q_push;
  packet_t q_push_data;
  packet_t q_head;
  logic    q_full;
  logic    q_empty;
  logic    take;

  assign in_stall = q_full;

  ps2c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_valid && !in_stall),
    .port_byte (port_byte),
    .from_aux  (from_aux),
    .push      (q_push),
    .push_data (q_push_data)
  );

  ps2c_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (take),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ps2c_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .q_valid   (!q_empty),
    .q_head    (q_head),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cursor_x  (cursor_x),
    .cursor_y  (cursor_y),
    .buttons   (buttons)
  );

  a_q_flags: assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue full and empty together");
  a_push_lands: assert property (@(posedge clk) disable iff (rst) q_push |=> !q_empty)
    else $error("pushed request missing from queue");
  a_take_shows: assert property (@(posedge clk) disable iff (rst) take |=> out_valid)
    else $error("taken request did not reach the result register");

endmodule

/* verif/tb_top.sv */
// Testbench for ps2_mouse_packet_cursor_core: drives PS/2 port bytes and screen size writes,
// predicts each cursor report and checks it field by field against the DUT output.
// Depends on ps2c_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_top;
  import ps2c_pkg::*;

  localparam int DRAIN       = 8;
  localparam int STUCK_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int N_PHASES    = 9;
  localparam int PER_PHASE   = 53;
  localparam int N_DIRECTED  = 25;
  localparam int COORD_SPAN  = 1 << OUT_W;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [BTN_W-1:0] btn;
  } cursor_rpt_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              aux;
    bit                pinned;
    int                x;
    int                y;
    int                btn;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        port_byte;
  logic              from_aux;
  logic              out_valid;
  logic              out_stall;
  logic [11:0]       cursor_x;
  logic [11:0]       cursor_y;
  logic [2:0]        buttons;
  logic              wr_en;
  logic              wr_index;
  logic [12:0]       wr_data;

  // predictor state
  phase_t            phase_m;
  logic [BYTE_W-1:0] hdr_m;
  logic [BYTE_W-1:0] xbyte_m;
  logic [OUT_W-1:0]  pos_x_m;
  logic [OUT_W-1:0]  pos_y_m;
  logic [DIM_W-1:0]  scr_w_m;
  logic [DIM_W-1:0]  scr_h_m;

  cursor_rpt_t       cursor_q[$];
  cursor_rpt_t       want;
  int                mismatches;
  int                burst_left;
  bit                hold_now;
  bit                hold_done;

  stim_row_t         dir_rows [0:N_DIRECTED-1];
  logic [DIM_W-1:0]  scr_w_set [0:N_PHASES-1];
  logic [DIM_W-1:0]  scr_h_set [0:N_PHASES-1];

  ps2_mouse_packet_cursor_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .port_byte(port_byte),
    .from_aux (from_aux),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_x (cursor_x),
    .cursor_y (cursor_y),
    .buttons  (buttons),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int delta9(input logic [BYTE_W-1:0] b, input logic neg, input logic ovf);
    int d;
    d = int'(b);
    if (neg) d -= 256;
    if (ovf) d = 0;
    return d;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_axis(input int v, input logic [DIM_W-1:0] lim_reg);
    int lim;
    lim = int'(lim_reg);
    if (lim == 0) lim = 1;
    if (lim > COORD_SPAN) lim = COORD_SPAN;
    if (v < 0) return '0;
    if (v >= lim) return OUT_W'(lim - 1);
    return OUT_W'(v);
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic aux,
                             output bit fired, output cursor_rpt_t rpt);
    int nx;
    int ny;
    fired = 1'b0;
    rpt = '0;
    if (!aux) return;
    case (phase_m)
      PH_X: begin
        xbyte_m = b;
        phase_m = PH_Y;
      end
      PH_Y: begin
        phase_m = PH_HDR;
        nx = int'(pos_x_m);
        ny = int'(pos_y_m);
        nx += delta9(xbyte_m, hdr_m[HDR_XSIGN], hdr_m[HDR_XOVF]);
        ny -= delta9(b, hdr_m[HDR_YSIGN], hdr_m[HDR_YOVF]);
        pos_x_m = clamp_axis(nx, scr_w_m);
        pos_y_m = clamp_axis(ny, scr_h_m);
        rpt.x = pos_x_m;
        rpt.y = pos_y_m;
        rpt.btn = hdr_m[BTN_W-1:0];
        fired = 1'b1;
      end
      default: begin
        // header without the sync bit is dropped to resync
        if (b[HDR_SYNC]) begin
          hdr_m = b;
          phase_m = PH_X;
        end else begin
          phase_m = PH_HDR;
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic aux,
                           input bit pinned, input cursor_rpt_t pin_rpt);
    int gap;
    bit fired;
    cursor_rpt_t rpt;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    port_byte <= b;
    from_aux  <= aux;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, aux, fired, rpt);
    if (fired) cursor_q.push_back(pinned ? pin_rpt : rpt);
  endtask

  // aux byte, sometimes preceded by a non-aux byte that must be ignored
  task automatic send_mouse_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 9) == 0) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    send_byte(b, 1'b1, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cursor_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wr_en    <= 1'b1;
    wr_index <= REG_SCREEN_WIDTH;
    wr_data  <= w;
    @(posedge clk);
    scr_w_m = w;
    wr_index <= REG_SCREEN_HEIGHT;
    wr_data  <= h;
    @(posedge clk);
    scr_h_m = h;
    wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cursor_q.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual x=%0d y=%0d buttons=%0d",
                 $time, cursor_x, cursor_y, buttons);
        mismatches++;
      end else begin
        want = cursor_q.pop_front();
        check_field("cursor_x", int'(want.x), int'(cursor_x));
        check_field("cursor_y", int'(want.y), int'(cursor_y));
        check_field("buttons", int'(want.btn), int'(buttons));
      end
    end
  end

  // receiver stall pattern, with one long hold-off while requests keep coming
  initial begin
    int mode;
    int seg;
    out_stall <= 1'b0;
    hold_done = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_now && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(10, 80);
        for (int i = 0; i < seg; i++) begin
          @(posedge clk);
          if (hold_now && !hold_done) break;
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= i[0];
          endcase
        end
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (rst !== 1'b0) @(posedge clk);
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sent;
    int pick;
    logic [1:0] drift;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] xb;
    logic [BYTE_W-1:0] yb;
    cursor_rpt_t pin;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    port_byte <= '0;
    from_aux  <= 1'b0;
    wr_en     <= 1'b0;
    wr_index  <= REG_SCREEN_WIDTH;
    wr_data   <= '0;
    mismatches = 0;
    burst_left = 0;
    hold_now   = 1'b0;

    phase_m = PH_HDR;
    hdr_m   = '0;
    xbyte_m = '0;
    pos_x_m = OUT_W'(CURSOR_X_RST);
    pos_y_m = OUT_W'(CURSOR_Y_RST);
    scr_w_m = WIDTH_RST;
    scr_h_m = HEIGHT_RST;

    dir_rows = '{
      '{8'h08, 1'b1, 1'b0, 0, 0, 0},
      '{8'h00, 1'b1, 1'b0, 0, 0, 0},
      '{8'h00, 1'b1, 1'b1, 320, 240, 0},
      '{8'h55, 1'b0, 1'b0, 0, 0, 0},
      '{8'h07, 1'b1, 1'b0, 0, 0, 0},
      '{8'h0F, 1'b1, 1'b0, 0, 0, 0},
      '{8'hFF, 1'b0, 1'b0, 0, 0, 0},
      '{8'h7F, 1'b1, 1'b0, 0, 0, 0},
      '{8'h7F, 1'b1, 1'b1, 447, 113, 7},
      '{8'h38, 1'b1, 1'b0, 0, 0, 0},
      '{8'h00, 1'b1, 1'b0, 0, 0, 0},
      '{8'h00, 1'b1, 1'b1, 191, 369, 0},
      '{8'hC8, 1'b1, 1'b0, 0, 0, 0},
      '{8'hFF, 1'b1, 1'b0, 0, 0, 0},
      '{8'hFF, 1'b1, 1'b1, 191, 369, 0},
      '{8'hF8, 1'b1, 1'b0, 0, 0, 0},
      '{8'h80, 1'b1, 1'b0, 0, 0, 0},
      '{8'h80, 1'b1, 1'b1, 191, 369, 0},
      '{8'h1D, 1'b1, 1'b0, 0, 0, 0},
      '{8'hFF, 1'b1, 1'b0, 0, 0, 0},
      '{8'h80, 1'b1, 1'b0, 0, 0, 0},
      '{8'h2A, 1'b1, 1'b0, 0, 0, 0},
      '{8'hFF, 1'b1, 1'b0, 0, 0, 0},
      '{8'h80, 1'b1, 1'b0, 0, 0, 0},
      '{8'h00, 1'b0, 1'b0, 0, 0, 0}
    };

    scr_w_set = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd4095, 13'd2, 13'd0, 13'd0, 13'd800};
    scr_h_set = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd2, 13'd4095, 13'd0, 13'd0, 13'd600};
    scr_w_set[6] = DIM_W'($urandom_range(1, 4096));
    scr_h_set[6] = DIM_W'($urandom_range(1, 4096));
    scr_w_set[7] = DIM_W'($urandom_range(4097, 8191));
    scr_h_set[7] = DIM_W'($urandom_range(1, 300));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      pin.x   = OUT_W'(dir_rows[i].x);
      pin.y   = OUT_W'(dir_rows[i].y);
      pin.btn = BTN_W'(dir_rows[i].btn);
      send_byte(dir_rows[i].b, dir_rows[i].aux, dir_rows[i].pinned, pin);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_screen(scr_w_set[ph], scr_h_set[ph]);
      if (ph == 2) hold_now = 1'b1;
      drift = 2'($urandom_range(0, 3));
      sent = 0;
      while (sent < PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          hdr = BYTE_W'($urandom_range(0, 255));
          xb  = BYTE_W'($urandom_range(0, 255));
          yb  = BYTE_W'($urandom_range(0, 255));
          hdr[HDR_SYNC] = 1'b1;
          // steer toward one corner so the clamps get hit
          if ($urandom_range(0, 1) == 1) begin
            hdr[HDR_XSIGN] = drift[0];
            hdr[HDR_YSIGN] = drift[1];
            hdr[HDR_XOVF]  = 1'b0;
            hdr[HDR_YOVF]  = 1'b0;
          end
          send_mouse_byte(hdr);
          send_mouse_byte(xb);
          send_mouse_byte(yb);
          sent += 3;
        end else if (pick < 90) begin
          hdr = BYTE_W'($urandom_range(0, 255));
          hdr[HDR_SYNC] = 1'b0;
          send_mouse_byte(hdr);
          sent++;
        end else begin
          send_mouse_byte(BYTE_W'($urandom_range(0, 255)));
          sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && cursor_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
